[src/irwg_pkg.sv]
`timescale 1ns / 1ps

package irwg_pkg;

    localparam int TABLE_WORDS = 256;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int WORD_W      = 32;
    localparam int X_IDX_LSB   = 2;
    localparam int Y_IDX_LSB   = 10;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_addr HALF_WORDS = t_addr'(TABLE_WORDS / 2);
    localparam t_addr LAST_ADDR  = t_addr'(TABLE_WORDS - 1);

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    localparam logic [1:0] SH_L13 = 2'd0;
    localparam logic [1:0] SH_R6  = 2'd1;
    localparam logic [1:0] SH_L2  = 2'd2;
    localparam logic [1:0] SH_R16 = 2'd3;

    function automatic t_word mix_shift(input t_word a, input logic [1:0] step);
        t_word r;
        unique case (step)
            SH_L13:  r = a ^ (a << 13);
            SH_R6:   r = a ^ (a >> 6);
            SH_L2:   r = a ^ (a << 2);
            SH_R16:  r = a ^ (a >> 16);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

[src/irwg_ram.sv]
`timescale 1ns / 1ps

module irwg_ram (
    input  logic              i_clk,
    input  irwg_pkg::t_ram_req i_req,
    output irwg_pkg::t_word   o_rdata
);
    import irwg_pkg::*;

    t_word r_mem [TABLE_WORDS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/irwg_ctrl.sv]
`timescale 1ns / 1ps

module irwg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  irwg_pkg::t_addr    i_seed_index,
    input  irwg_pkg::t_word    i_seed_word,
    output irwg_pkg::t_ram_req o_mix_req,
    input  irwg_pkg::t_word    i_mix_rdata,
    output irwg_pkg::t_ram_req o_res_req,
    output logic               o_res_valid,
    input  logic               i_res_ready
);
    import irwg_pkg::*;

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_INIT     = 4'd2;
    localparam logic [3:0] S_RD_H     = 4'd3;
    localparam logic [3:0] S_RD_I     = 4'd4;
    localparam logic [3:0] S_WR_Y     = 4'd5;
    localparam logic [3:0] S_RD_J     = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;
    localparam logic [3:0] S_RES_DATA = 4'd8;

    logic [3:0] r_state, n_state;
    t_addr      r_k, n_k;
    t_addr      r_pos, n_pos;
    t_word      r_a, n_a;
    t_word      r_b, n_b;
    t_word      r_cnt, n_cnt;
    t_word      r_x, n_x;
    t_word      r_y, n_y;
    t_word      w_sum;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_pos     = r_pos;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt     = r_cnt;
        n_x       = r_x;
        n_y       = r_y;
        w_sum     = '0;
        o_mix_req = '0;
        o_res_req = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_mix_req.we    = 1'b1;
                o_mix_req.waddr = r_k;
                o_res_req.we    = 1'b1;
                o_res_req.waddr = r_k;
                n_k = r_k + t_addr'(1);
                if (r_k == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_mode) begin
                        o_mix_req.we    = 1'b1;
                        o_mix_req.waddr = i_seed_index;
                        o_mix_req.wdata = i_seed_word;
                        n_a   = '0;
                        n_b   = '0;
                        n_cnt = '0;
                    end else if (r_pos == '0) begin
                        n_cnt   = r_cnt + t_word'(1);
                        n_state = S_INIT;
                    end else begin
                        o_res_req.re    = 1'b1;
                        o_res_req.raddr = r_pos;
                        n_state = S_RES_DATA;
                    end
                end
            end
            S_INIT: begin
                n_b = r_b + r_cnt;
                o_mix_req.re    = 1'b1;
                o_mix_req.raddr = r_k;
                n_state = S_RD_H;
            end
            S_RD_H: begin
                n_x = i_mix_rdata;
                o_mix_req.re    = 1'b1;
                o_mix_req.raddr = r_k + HALF_WORDS;
                n_state = S_RD_I;
            end
            S_RD_I: begin
                n_a = mix_shift(r_a, r_k[1:0]) + i_mix_rdata;
                o_mix_req.re    = 1'b1;
                o_mix_req.raddr = r_x[X_IDX_LSB +: ADDR_W];
                n_state = S_WR_Y;
            end
            S_WR_Y: begin
                w_sum = r_a + r_b + i_mix_rdata;
                n_y   = w_sum;
                o_mix_req.we    = 1'b1;
                o_mix_req.waddr = r_k;
                o_mix_req.wdata = w_sum;
                n_state = S_RD_J;
            end
            S_RD_J: begin
                o_mix_req.re    = 1'b1;
                o_mix_req.raddr = r_y[Y_IDX_LSB +: ADDR_W];
                n_state = S_FIN;
            end
            S_FIN: begin
                w_sum = r_x + i_mix_rdata;
                n_b   = w_sum;
                o_res_req.we    = 1'b1;
                o_res_req.waddr = r_k;
                o_res_req.wdata = w_sum;
                n_k = r_k + t_addr'(1);
                if (r_k == LAST_ADDR) begin
                    o_res_req.re    = 1'b1;
                    o_res_req.raddr = r_pos;
                    n_state = S_RES_DATA;
                end else begin
                    o_mix_req.re    = 1'b1;
                    o_mix_req.raddr = r_k + t_addr'(1);
                    n_state = S_RD_H;
                end
            end
            S_RES_DATA: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_pos   = r_pos + t_addr'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= '0;
            r_pos   <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_a     <= n_a;
            r_b     <= n_b;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

endmodule

[src/isaac_random_word_generator.sv]
`timescale 1ns / 1ps

// ISAAC-style 32-bit random word generator. A transaction with tuser high loads
// seed_word into mixing-table entry seed_index and clears a, b and the round
// counter; tuser low requests the next random word. Reset starts a clearing pass
// that zeroes all 256 entries of both tables, during which no transaction is taken.
// A request at read position 1..255 is served by one results-table read. A
// request at read position 0 first regenerates all 256 words, one word at a
// time, paced by the single read port of the mixing-table memory (four reads
// and one write per word), and then reads results-table entry 0.

module isaac_random_word_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // seed_index[7:0], seed_word[39:8]
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // random_word
);
    import irwg_pkg::*;

    t_ram_req w_mix_req;
    t_ram_req w_res_req;
    t_word    w_mix_rdata;
    t_word    w_res_rdata;
    logic     w_res_valid;
    logic     w_res_ready;
    logic     r_out_valid;
    t_word    r_out_data;

    irwg_ram u_mix_ram (
        .i_clk   (i_clk),
        .i_req   (w_mix_req),
        .o_rdata (w_mix_rdata)
    );

    irwg_ram u_res_ram (
        .i_clk   (i_clk),
        .i_req   (w_res_req),
        .o_rdata (w_res_rdata)
    );

    irwg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_mode       (s_axis_tuser),
        .i_seed_index (s_axis_tdata[ADDR_W-1:0]),
        .i_seed_word  (s_axis_tdata[ADDR_W +: WORD_W]),
        .o_mix_req    (w_mix_req),
        .i_mix_rdata  (w_mix_rdata),
        .o_res_req    (w_res_req),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready)
    );

    // output slot free when empty or draining this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= w_res_rdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
